>>> hw/rtl/mpfc_pkg.sv
// Shared types, constants and the magic prefix table of the file classifier.
package mpfc_pkg;

  localparam int NUM_ENTRIES = 48;
  localparam int MAX_PREFIX  = 26;
  localparam int PAT_W       = 8 * MAX_PREFIX;
  localparam int POS_W       = 5;
  localparam int ENTRY_W     = 6;

  localparam logic [ENTRY_W-1:0] NO_MATCH = ENTRY_W'(NUM_ENTRIES);
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  typedef enum logic [3:0] {
    FT_DOS_EXE      = 4'd0,
    FT_RAR          = 4'd1,
    FT_ZIP          = 4'd2,
    FT_GZIP         = 4'd3,
    FT_BZIP         = 4'd4,
    FT_SZDD         = 4'd5,
    FT_CAB          = 4'd6,
    FT_CHM          = 4'd7,
    FT_MAIL         = 4'd8,
    FT_OLE2         = 4'd9,
    FT_DATA         = 4'd10,
    FT_UNKNOWN_TEXT = 4'd11,
    FT_UNKNOWN_DATA = 4'd12
  } file_type_t;

  typedef struct packed {
    logic [POS_W-1:0] len;
    file_type_t       kind;
    logic [PAT_W-1:0] pat;
  } rom_entry_t;

  typedef struct packed {
    logic [NUM_ENTRIES-1:0] alive;
    logic                   printable;
    file_type_t             file_type;
    logic [ENTRY_W-1:0]     winner;
  } scan_res_t;

  function automatic rom_entry_t rom_entry(input logic [ENTRY_W-1:0] idx);
    rom_entry_t e;
    e = '{len: 5'd2, kind: FT_DATA, pat: '0};
    case (idx)
      6'd0:  e = '{5'd2,  FT_DOS_EXE, PAT_W'("MZ")};
      6'd1:  e = '{5'd4,  FT_RAR,     PAT_W'("Rar!")};
      6'd2:  e = '{5'd4,  FT_ZIP,     PAT_W'({"PK", 8'h03, 8'h04})};
      6'd3:  e = '{5'd2,  FT_GZIP,    PAT_W'(16'h1F8B)};
      6'd4:  e = '{5'd3,  FT_BZIP,    PAT_W'("BZh")};
      6'd5:  e = '{5'd4,  FT_SZDD,    PAT_W'("SZDD")};
      6'd6:  e = '{5'd4,  FT_CAB,     PAT_W'("MSCF")};
      6'd7:  e = '{5'd4,  FT_CHM,     PAT_W'("ITSF")};
      6'd8:  e = '{5'd5,  FT_MAIL,    PAT_W'("From ")};
      6'd9:  e = '{5'd8,  FT_MAIL,    PAT_W'("Received")};
      6'd10: e = '{5'd13, FT_MAIL,    PAT_W'("Return-Path: ")};
      6'd11: e = '{5'd13, FT_MAIL,    PAT_W'("Return-path: ")};
      6'd12: e = '{5'd14, FT_MAIL,    PAT_W'("Delivered-To: ")};
      6'd13: e = '{5'd8,  FT_MAIL,    PAT_W'("X-UIDL: ")};
      6'd14: e = '{5'd17, FT_MAIL,    PAT_W'("X-Apparently-To: ")};
      6'd15: e = '{5'd17, FT_MAIL,    PAT_W'("X-Envelope-From: ")};
      6'd16: e = '{5'd15, FT_MAIL,    PAT_W'("X-Original-To: ")};
      6'd17: e = '{5'd11, FT_MAIL,    PAT_W'(88'h582D53796D616E7465632D)};
      6'd18: e = '{5'd5,  FT_MAIL,    PAT_W'("X-EVS")};
      6'd19: e = '{5'd11, FT_MAIL,    PAT_W'("X-Real-To: ")};
      6'd20: e = '{5'd6,  FT_MAIL,    PAT_W'(">From ")};
      6'd21: e = '{5'd6,  FT_MAIL,    PAT_W'("Date: ")};
      6'd22: e = '{5'd12, FT_MAIL,    PAT_W'("Message-Id: ")};
      6'd23: e = '{5'd12, FT_MAIL,    PAT_W'("Message-ID: ")};
      6'd24: e = '{5'd13, FT_MAIL,    PAT_W'("Envelope-to: ")};
      6'd25: e = '{5'd15, FT_MAIL,    PAT_W'("Delivery-date: ")};
      6'd26: e = '{5'd4,  FT_MAIL,    PAT_W'("To: ")};
      6'd27: e = '{5'd9,  FT_MAIL,    PAT_W'("Subject: ")};
      6'd28: e = '{5'd5,  FT_MAIL,    PAT_W'("For: ")};
      6'd29: e = '{5'd6,  FT_MAIL,    PAT_W'("From: ")};
      6'd30: e = '{5'd14, FT_MAIL,
                   PAT_W'({8'h76, 8'h3A, 8'h0D, 8'h0A, "Received: "})};
      6'd31: e = '{5'd13, FT_MAIL,
                   PAT_W'({8'h76, 8'h3A, 8'h0A, "Received: "})};
      6'd32: e = '{5'd26, FT_MAIL,
                   PAT_W'({120'h48692E205468697320697320746865,
                           88'h20716D61696C2D73656E64})};
      6'd33: e = '{5'd8,  FT_OLE2,    PAT_W'(64'hD0CF11E0A1B11AE1)};
      6'd34: e = '{5'd4,  FT_DATA,    PAT_W'(32'h000001B3)};
      6'd35: e = '{5'd4,  FT_DATA,    PAT_W'(32'h000001BA)};
      6'd36: e = '{5'd4,  FT_DATA,    PAT_W'("RIFF")};
      6'd37: e = '{5'd3,  FT_DATA,    PAT_W'("GIF")};
      6'd38: e = '{5'd4,  FT_DATA,    PAT_W'(32'h89504E47)};
      6'd39: e = '{5'd4,  FT_DATA,    PAT_W'(32'hFFD8FF00)};
      6'd40: e = '{5'd2,  FT_DATA,    PAT_W'("BM")};
      6'd41: e = '{5'd4,  FT_DATA,    PAT_W'("OggS")};
      6'd42: e = '{5'd3,  FT_DATA,    PAT_W'("ID3")};
      6'd43: e = '{5'd3,  FT_DATA,    PAT_W'(24'hFFFB90)};
      6'd44: e = '{5'd5,  FT_DATA,    PAT_W'("%PDF-")};
      6'd45: e = '{5'd11, FT_DATA,    PAT_W'(88'h252150532D41646F62652D)};
      6'd46: e = '{5'd7,  FT_DATA,    PAT_W'(56'h3026B2758E66CF)};
      6'd47: e = '{5'd4,  FT_DATA,    PAT_W'(".RMF")};
      default: e = '{len: 5'd2, kind: FT_DATA, pat: '0};
    endcase
    return e;
  endfunction

  function automatic logic [7:0] entry_byte(input rom_entry_t e,
                                            input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] k;
    k = e.len - 5'd1 - pos;
    return e.pat[{k, 3'b000} +: 8];
  endfunction

endpackage

>>> hw/rtl/magic_prefix_file_classifier_top.sv
// Top level of the magic prefix file classifier with input and result registers.
// The block takes one buffer byte per cycle and sustains one transaction per cycle
// end to end unless stalled as below: each byte is registered, compared against
// all 48 prefixes at its position and folded into the match state in the following
// cycle. The byte marked last yields one result transaction, registered as that
// byte leaves its input register, and the state is cleared at the same time, so
// the next buffer can start in the cycle right after. Only the result register
// being full and stalled holds the input back, and only when a last byte waits.
module magic_prefix_file_classifier_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_file_type,
  output logic [5:0] out_matched_entry
);

  logic                              in_v_r;
  logic [7:0]                        in_byte_r;
  logic                              in_last_r;
  logic [mpfc_pkg::NUM_ENTRIES-1:0]  alive_r;
  logic [mpfc_pkg::POS_W-1:0]        pos_r;
  logic                              printable_r;
  logic                              out_v_r;
  mpfc_pkg::file_type_t              out_type_r;
  logic [mpfc_pkg::ENTRY_W-1:0]      out_entry_r;
  logic                              adv;
  logic                              in_acc;
  mpfc_pkg::scan_res_t               res;

  assign adv      = in_v_r && (!in_last_r || !out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  mpfc_scan u_scan (
    .data_byte (in_byte_r),
    .pos       (pos_r),
    .alive     (alive_r),
    .printable (printable_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r     <= '1;
      pos_r       <= '0;
      printable_r <= 1'b1;
    end else if (adv) begin
      if (in_last_r) begin
        alive_r     <= '1;
        pos_r       <= '0;
        printable_r <= 1'b1;
      end else begin
        alive_r     <= res.alive;
        printable_r <= res.printable;
        if (pos_r < mpfc_pkg::POS_W'(mpfc_pkg::MAX_PREFIX)) begin
          pos_r <= pos_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      out_type_r  <= res.file_type;
      out_entry_r <= res.winner;
    end
  end

  assign out_valid         = out_v_r;
  assign out_file_type     = out_type_r;
  assign out_matched_entry = out_entry_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |-> !(out_v_r && out_stall))
    else $error("Result register overwritten while stalled.");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> (pos_r == '0 && (&alive_r) && printable_r))
    else $error("Match state not cleared after the last byte.");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= mpfc_pkg::POS_W'(mpfc_pkg::MAX_PREFIX))
    else $error("Byte position beyond the longest prefix.");

  a_fallback_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_entry_r == mpfc_pkg::NO_MATCH) ==
                 (out_type_r == mpfc_pkg::FT_UNKNOWN_TEXT ||
                  out_type_r == mpfc_pkg::FT_UNKNOWN_DATA)))
    else $error("Fallback type does not agree with the matched entry.");

endmodule

>>> hw/rtl/mpfc_scan.sv
// Per-byte prefix compare, printable tracking and first-match selection.
module mpfc_scan (
  input  logic [7:0]                      data_byte,
  input  logic [mpfc_pkg::POS_W-1:0]      pos,
  input  logic [mpfc_pkg::NUM_ENTRIES-1:0] alive,
  input  logic                            printable,
  output mpfc_pkg::scan_res_t             res
);

  logic [mpfc_pkg::NUM_ENTRIES-1:0] alive_nxt;
  logic [mpfc_pkg::NUM_ENTRIES-1:0] cand;
  logic [mpfc_pkg::POS_W-1:0]       count;
  mpfc_pkg::rom_entry_t             e;

  assign count = pos + 5'd1;

  always_comb begin
    alive_nxt = alive;
    cand      = '0;
    for (int i = 0; i < mpfc_pkg::NUM_ENTRIES; i++) begin
      e = mpfc_pkg::rom_entry(mpfc_pkg::ENTRY_W'(i));
      if (pos < e.len && mpfc_pkg::entry_byte(e, pos) != data_byte) begin
        alive_nxt[i] = 1'b0;
      end
      cand[i] = alive_nxt[i] && (e.len <= count);
    end
  end

  always_comb begin
    mpfc_pkg::rom_entry_t w;
    res.alive     = alive_nxt;
    res.printable = printable && (data_byte >= mpfc_pkg::PRINT_LO)
                    && (data_byte <= mpfc_pkg::PRINT_HI);
    res.winner    = mpfc_pkg::NO_MATCH;
    res.file_type = res.printable ? mpfc_pkg::FT_UNKNOWN_TEXT
                                  : mpfc_pkg::FT_UNKNOWN_DATA;
    for (int i = mpfc_pkg::NUM_ENTRIES - 1; i >= 0; i--) begin
      w = mpfc_pkg::rom_entry(mpfc_pkg::ENTRY_W'(i));
      if (cand[i]) begin
        res.winner    = mpfc_pkg::ENTRY_W'(i);
        res.file_type = w.kind;
      end
    end
  end

endmodule
